// File: rtl/afd_pkg.sv
// ----------------------------------------------------------------------------
// afd_pkg
// Shared widths, reset values, codes and types of the accelerometer fall
// detector.
// ----------------------------------------------------------------------------
package afd_pkg;

    localparam int ACCEL_W    = 16;
    localparam int OP_W       = 2;
    localparam int DEV_W      = 16;
    localparam int ROOT_W     = 16;
    localparam int REM_W      = ROOT_W + 1;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int ENTRY_W    = 15;
    localparam int ENTRY_MAX_INT = 32767;
    localparam int FTHR_W     = 15;
    localparam int CNT_W      = 16;
    localparam int SUM_OUT_W  = 22;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int WINDOW_LEN_DEF = 100;

    localparam logic [ENTRY_W-1:0]   ENTRY_MAX   = '1;
    localparam logic [SUM_OUT_W-1:0] SUM_OUT_MAX = '1;
    localparam logic [CNT_W-1:0]     CNT_MAX     = '1;

    localparam logic signed [ACCEL_W-1:0] GRAVITY_RST = 16'sd15695;
    localparam logic [DEV_W-1:0]          LIMIT_RST   = 16'd10000;
    localparam logic [FTHR_W-1:0]         FTHR_RST    = 15'd2560;
    localparam logic [CNT_W-1:0]          HOLDOFF_RST = 16'd1000;

    typedef logic [OP_W-1:0]      op_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam op_t OP_SAMPLE = 2'd0;
    localparam op_t OP_TICK   = 2'd1;
    localparam op_t OP_DONE   = 2'd2;

    localparam cfg_idx_t REG_GRAVITY = 2'd0;
    localparam cfg_idx_t REG_LIMIT   = 2'd1;
    localparam cfg_idx_t REG_FTHR    = 2'd2;
    localparam cfg_idx_t REG_HOLDOFF = 2'd3;

    typedef struct packed {
        logic             start;
        logic [DEV_W-1:0] dev;
    } isqrt_req_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } isqrt_rsp_t;

endpackage

// File: rtl/afd_if.sv
// ----------------------------------------------------------------------------
// afd_if
// Valid/ready channels of the fall detector: input items, results and
// configuration writes.
// ----------------------------------------------------------------------------
interface afd_item_if;
    import afd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           op;
    logic signed [ACCEL_W-1:0] accel_z;

    modport source (output valid, output op, output accel_z, input ready);
    modport sink   (input valid, input op, input accel_z, output ready);
endinterface

interface afd_result_if;
    import afd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 fall_detected;
    logic [SUM_OUT_W-1:0] window_sum;

    modport source (output valid, output fall_detected, output window_sum, input ready);
    modport sink   (input valid, input fall_detected, input window_sum, output ready);
endinterface

interface afd_cfg_if;
    import afd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/afd_isqrt.sv
// ----------------------------------------------------------------------------
// afd_isqrt
// Digit-serial integer square root of dev * 2^16, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module afd_isqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  afd_pkg::isqrt_req_t req,
    output afd_pkg::isqrt_rsp_t rsp
);
    import afd_pkg::*;

    localparam int STEP_W = $clog2(ROOT_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ROOT_STEPS - 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [DEV_W-1:0]    rad_reg, rad_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;

    logic [REM_W+1:0]    rem_sh;
    logic [REM_W+1:0]    trial;
    logic [REM_W+1:0]    rem_sub;
    logic                take;

    // trial subtrahend is 4*root + 1
    assign rem_sh  = {rem_reg, rad_reg[DEV_W-1 -: 2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign take    = (rem_sh >= trial);
    assign rem_sub = rem_sh - trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rad_next  = req.dev;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[DEV_W-3:0], 2'b00};
            rem_next  = take ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
            root_next = {root_reg[ROOT_W-2:0], take};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

endmodule

// File: rtl/accel_fall_detector.sv
// ----------------------------------------------------------------------------
// accel_fall_detector
// Moving-window fall detector on accelerometer Z samples: Q8 square root of
// the deviation from gravity, ring of contributions, threshold plus holdoff.
// ----------------------------------------------------------------------------
//  channel  dir  payload                        transaction
//  item     in   op, accel_z                    one sample, tick or seq done
//  result   out  fall_detected, window_sum      one per item
//  cfg      in   index, data                    one register write
//
//  A sample holds item.ready low through the DIFF, ABS, ROOT, SUM, DECIDE and
//  OUT states; in ROOT the two-bits-per-cycle square-root recurrence in
//  afd_isqrt runs and its root is picked up once done is seen.
//  A tick, sequence-done or unused op holds item.ready low through MISC and OUT.
//  Reset (rst_n, async) clears the window valid bits, sum, index and counter.
//  A result not taken holds the block in its output state; cfg never stalls.
// ----------------------------------------------------------------------------
module accel_fall_detector #(
    parameter int WINDOW_LEN = afd_pkg::WINDOW_LEN_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    afd_item_if.sink     item,
    afd_result_if.source result,
    afd_cfg_if.sink      cfg
);
    import afd_pkg::*;

    localparam int IDX_W = $clog2(WINDOW_LEN);
    localparam int SUM_W = $clog2(WINDOW_LEN * ENTRY_MAX_INT + 1);
    localparam int MUL_W = $clog2(WINDOW_LEN + 1);
    localparam int THR_W = FTHR_W + MUL_W;
    localparam int EXT_W = (SUM_W > SUM_OUT_W) ? SUM_W : SUM_OUT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_LEN - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIFF   = 3'd1;
    localparam logic [2:0] S_ABS    = 3'd2;
    localparam logic [2:0] S_ROOT   = 3'd3;
    localparam logic [2:0] S_SUM    = 3'd4;
    localparam logic [2:0] S_DECIDE = 3'd5;
    localparam logic [2:0] S_MISC   = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    logic [2:0]                state_reg, state_next;
    op_t                       op_reg, op_next;
    logic signed [ACCEL_W-1:0] accel_reg, accel_next;
    logic [ACCEL_W:0]          diff_reg, diff_next;
    logic                      in_range_reg, in_range_next;
    logic [ENTRY_W-1:0]        contrib_reg, contrib_next;

    logic signed [ACCEL_W-1:0] gravity_reg, gravity_next;
    logic [DEV_W-1:0]          limit_reg, limit_next;
    logic [FTHR_W-1:0]         fthr_reg, fthr_next;
    logic [CNT_W-1:0]          holdoff_reg, holdoff_next;
    logic [THR_W-1:0]          thr_scaled_reg;

    logic [IDX_W-1:0]          widx_reg, widx_next;
    logic [WINDOW_LEN-1:0]     vld_reg, vld_next;
    logic                      old_vld_reg;
    logic [ENTRY_W-1:0]        rd_data_reg;
    logic [ENTRY_W-1:0]        win_mem [WINDOW_LEN];
    logic                      mem_we;

    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic [CNT_W-1:0]          elapsed_reg, elapsed_next;
    logic                      fall_reg, fall_next;

    logic                      out_valid_reg, out_valid_next;
    logic                      out_fall_reg;
    logic [SUM_OUT_W-1:0]      out_sum_reg;
    logic                      out_load;

    logic [ACCEL_W:0]          dev_full;
    logic [DEV_W-1:0]          dev;
    logic [ENTRY_W-1:0]        old_entry;
    logic [EXT_W-1:0]          sum_ext;
    logic [SUM_OUT_W-1:0]      sum_sat;
    logic                      detect;
    logic                      item_acc;

    isqrt_req_t                sq_req;
    isqrt_rsp_t                sq_rsp;

    afd_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sq_req),
        .rsp   (sq_rsp)
    );

    assign item.ready   = (state_reg == S_IDLE);
    assign item_acc     = item.valid && item.ready;
    assign cfg.ready    = 1'b1;

    assign dev_full  = diff_reg[ACCEL_W] ? ((ACCEL_W + 1)'(0) - diff_reg) : diff_reg;
    assign dev       = dev_full[DEV_W-1:0];
    assign old_entry = old_vld_reg ? rd_data_reg : '0;

    assign sq_req.start = (state_reg == S_ABS);
    assign sq_req.dev   = dev;

    assign detect = (THR_W'(sum_reg) > thr_scaled_reg) && (elapsed_reg > holdoff_reg);

    assign sum_ext = EXT_W'(sum_reg);
    assign sum_sat = (sum_ext > EXT_W'(SUM_OUT_MAX)) ? SUM_OUT_MAX : sum_ext[SUM_OUT_W-1:0];

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || result.ready);

    always_comb
    begin
        gravity_next = gravity_reg;
        limit_next   = limit_reg;
        fthr_next    = fthr_reg;
        holdoff_next = holdoff_reg;
        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_GRAVITY: gravity_next = cfg.data;
                REG_LIMIT:   limit_next   = cfg.data;
                REG_FTHR:    fthr_next    = cfg.data[FTHR_W-1:0];
                REG_HOLDOFF: holdoff_next = cfg.data;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        accel_next    = accel_reg;
        diff_next     = diff_reg;
        in_range_next = in_range_reg;
        contrib_next  = contrib_reg;
        widx_next     = widx_reg;
        vld_next      = vld_reg;
        sum_next      = sum_reg;
        elapsed_next  = elapsed_reg;
        fall_next     = fall_reg;
        mem_we        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_acc)
                begin
                    op_next    = item.op;
                    accel_next = item.accel_z;
                    fall_next  = 1'b0;
                    state_next = (item.op == OP_SAMPLE) ? S_DIFF : S_MISC;
                end
            end
            S_DIFF:
            begin
                diff_next  = (ACCEL_W + 1)'($signed({accel_reg[ACCEL_W-1], accel_reg})
                           - $signed({gravity_reg[ACCEL_W-1], gravity_reg}));
                state_next = S_ABS;
            end
            S_ABS:
            begin
                // root starts here; the outgoing entry leaves the sum meanwhile
                in_range_next = (dev < limit_reg);
                sum_next      = sum_reg - SUM_W'(old_entry);
                state_next    = S_ROOT;
            end
            S_ROOT:
            begin
                if (sq_rsp.done)
                begin
                    if (!in_range_reg)
                        contrib_next = '0;
                    else if (sq_rsp.root[ROOT_W-1])
                        contrib_next = ENTRY_MAX;
                    else
                        contrib_next = sq_rsp.root[ENTRY_W-1:0];
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                mem_we             = 1'b1;
                vld_next[widx_reg] = 1'b1;
                sum_next           = sum_reg + SUM_W'(contrib_reg);
                widx_next          = (widx_reg == LAST_IDX) ? '0 : widx_reg + 1'b1;
                state_next         = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (detect)
                begin
                    fall_next    = 1'b1;
                    vld_next     = '0;
                    sum_next     = '0;
                    elapsed_next = '0;
                end
                state_next = S_OUT;
            end
            S_MISC:
            begin
                if (op_reg == OP_TICK)
                begin
                    if (elapsed_reg != CNT_MAX)
                        elapsed_next = elapsed_reg + 1'b1;
                end
                else if (op_reg == OP_DONE)
                begin
                    elapsed_next = '0;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gravity_reg   <= GRAVITY_RST;
            limit_reg     <= LIMIT_RST;
            fthr_reg      <= FTHR_RST;
            holdoff_reg   <= HOLDOFF_RST;
            widx_reg      <= '0;
            vld_reg       <= '0;
            old_vld_reg   <= 1'b0;
            sum_reg       <= '0;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gravity_reg   <= gravity_next;
            limit_reg     <= limit_next;
            fthr_reg      <= fthr_next;
            holdoff_reg   <= holdoff_next;
            widx_reg      <= widx_next;
            vld_reg       <= vld_next;
            old_vld_reg   <= vld_reg[widx_reg];
            sum_reg       <= sum_next;
            elapsed_reg   <= elapsed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        accel_reg      <= accel_next;
        diff_reg       <= diff_next;
        in_range_reg   <= in_range_next;
        contrib_reg    <= contrib_next;
        fall_reg       <= fall_next;
        thr_scaled_reg <= THR_W'(fthr_reg) * THR_W'(WINDOW_LEN);
        if (out_load)
        begin
            out_fall_reg <= fall_reg;
            out_sum_reg  <= sum_sat;
        end
    end

    // window ring: one write port, one registered read at the ring index
    always_ff @(posedge clk)
    begin
        rd_data_reg <= win_mem[widx_reg];
        if (mem_we)
            win_mem[widx_reg] <= contrib_reg;
    end

    assign result.valid         = out_valid_reg;
    assign result.fall_detected = out_fall_reg;
    assign result.window_sum    = out_sum_reg;

endmodule

// File: rtl/afd_checker.sv
// ----------------------------------------------------------------------------
// afd_checker
// Port-level checks of the fall detector, bound to the top level.
// ----------------------------------------------------------------------------
module afd_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           item_valid,
    input logic                           item_ready,
    input logic                           res_valid,
    input logic                           res_ready,
    input logic                           res_fall,
    input logic [afd_pkg::SUM_OUT_W-1:0]  res_sum
);
    import afd_pkg::*;

    // a stalled result keeps valid
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result valid dropped while stalled");

    // a stalled result keeps its payload
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_fall) && $stable(res_sum))
        else $error("result payload changed while stalled");

    // one transaction at a time: ready drops right after acceptance
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item accepted while busy");

    // a detection clears the window
    a_fall_clears: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_fall |-> res_sum == '0)
        else $error("fall reported with nonzero window sum");

    // a new result is only produced while the input side is busy
    a_res_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> !$past(item_ready))
        else $error("result appeared without work in progress");

endmodule

bind accel_fall_detector afd_checker u_afd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_fall   (result.fall_detected),
    .res_sum    (result.window_sum)
);

// File: sim/afd_fall_monitor.sv
// ----------------------------------------------------------------------------
// afd_fall_monitor
// Watches the item, result and register channels of the fall detector. It
// keeps its own window, sum, ms counter and registers, works out the outcome
// of every accepted item and compares it with the results in order.
// ----------------------------------------------------------------------------
module afd_fall_monitor #(
    parameter int WINDOW_LEN = afd_pkg::WINDOW_LEN_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    afd_item_if    item,
    afd_result_if  result,
    afd_cfg_if     cfg,
    output int     errors,
    output int     pending
);
    import afd_pkg::*;

    typedef struct packed {
        logic                 fall;
        logic [SUM_OUT_W-1:0] sum;
    } detect_out_t;

    detect_out_t awaited_q[$];

    logic signed [ACCEL_W-1:0] gravity;
    logic [DEV_W-1:0]          dev_limit;
    logic [FTHR_W-1:0]         fall_thr;
    logic [CNT_W-1:0]          holdoff;

    logic [ENTRY_W-1:0] window_model [WINDOW_LEN];
    int unsigned        slot;
    int unsigned        window_total;
    logic [CNT_W-1:0]   ms_count;

    task automatic report_mismatch(string field, longint got, longint want);
        $display("%0t fall monitor: %s got %0d expected %0d", $time, field, got, want);
        errors++;
    endtask

    task automatic reset_model();
        gravity   = GRAVITY_RST;
        dev_limit = LIMIT_RST;
        fall_thr  = FTHR_RST;
        holdoff   = HOLDOFF_RST;
        foreach (window_model[i])
            window_model[i] = '0;
        slot         = 0;
        window_total = 0;
        ms_count     = '0;
    endtask

    // floor(sqrt(dev * 65536)), one result bit per pass from the top
    function automatic logic [ENTRY_W-1:0] q8_root(int unsigned dev);
        longint unsigned rad;
        longint unsigned trial;
        int unsigned     root;
        rad  = dev;
        rad  = rad << 16;
        root = 0;
        for (int b = 15; b >= 0; b--)
        begin
            trial = root | (32'd1 << b);
            if (trial * trial <= rad)
                root = 32'(trial);
        end
        return (root > ENTRY_MAX_INT) ? ENTRY_MAX : root[ENTRY_W-1:0];
    endfunction

    function automatic detect_out_t detect_step(op_t op, logic signed [ACCEL_W-1:0] z);
        detect_out_t        outcome;
        int                 diff;
        int unsigned        dev;
        logic [ENTRY_W-1:0] contrib;
        outcome.fall = 1'b0;
        case (op)
            OP_SAMPLE:
            begin
                diff    = z - gravity;
                dev     = (diff < 0) ? -diff : diff;
                contrib = (dev < dev_limit) ? q8_root(dev) : '0;
                window_total = window_total - window_model[slot] + contrib;
                window_model[slot] = contrib;
                slot = (slot + 1) % WINDOW_LEN;
                if (window_total > int'(fall_thr) * WINDOW_LEN && ms_count > holdoff)
                begin
                    // window cleared, ring position keeps going
                    outcome.fall = 1'b1;
                    foreach (window_model[i])
                        window_model[i] = '0;
                    window_total = 0;
                    ms_count     = '0;
                end
            end
            OP_TICK:
            begin
                if (ms_count != CNT_MAX)
                    ms_count++;
            end
            OP_DONE:
                ms_count = '0;
            default: ;
        endcase
        outcome.sum = (window_total > SUM_OUT_MAX) ? SUM_OUT_MAX
                                                   : window_total[SUM_OUT_W-1:0];
        return outcome;
    endfunction

    task automatic compare_result();
        detect_out_t want;
        if (awaited_q.size() == 0)
        begin
            report_mismatch("unexpected result, window_sum", result.window_sum, 0);
            return;
        end
        want = awaited_q.pop_front();
        if (result.fall_detected !== want.fall)
            report_mismatch("fall_detected", result.fall_detected, want.fall);
        if (result.window_sum !== want.sum)
            report_mismatch("window_sum", result.window_sum, want.sum);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_model();
            awaited_q.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (result.valid && result.ready)
                compare_result();
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_GRAVITY: gravity   = cfg.data;
                    REG_LIMIT:   dev_limit = cfg.data;
                    REG_FTHR:    fall_thr  = cfg.data[FTHR_W-1:0];
                    REG_HOLDOFF: holdoff   = cfg.data;
                    default: ;
                endcase
            end
            if (item.valid && item.ready)
                awaited_q.push_back(detect_step(item.op, item.accel_z));
            pending = awaited_q.size();
        end
    end

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the accelerometer fall detector: directed edge cases, the ms
// counter run up against the holdoff, then random phases under several
// register settings, most with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module tb;
    import afd_pkg::*;

    localparam op_t OP_UNUSED     = 2'd3;
    localparam int  WATCHDOG_LIMIT = 4000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic idling = 1'b1;

    logic signed [ACCEL_W-1:0] cur_grav  = GRAVITY_RST;
    logic [DEV_W-1:0]          cur_limit = LIMIT_RST;

    int mismatches;
    int outstanding;
    int quiet_cycles = 0;

    afd_item_if   item();
    afd_result_if result();
    afd_cfg_if    cfg();

    accel_fall_detector dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg)
    );

    afd_fall_monitor monitor (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .result  (result),
        .cfg     (cfg),
        .errors  (mismatches),
        .pending (outstanding)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result side back-pressure
    initial
    begin
        result.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result.ready <= !(idling && $urandom_range(99) < 21);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item.valid && item.ready) || (result.valid && result.ready)
            || (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send(op_t op, logic [ACCEL_W-1:0] z);
        while (idling && $urandom_range(99) < 21)
        begin
            item.valid <= 1'b0;
            @(posedge clk);
        end
        item.valid   <= 1'b1;
        item.op      <= op;
        item.accel_z <= z;
        do @(posedge clk); while (!item.ready);
    endtask

    // called in the step of the last item transaction
    task automatic drain();
        item.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge clk); while (!cfg.ready);
    endtask

    task automatic load_config(logic [15:0] g, logic [15:0] lim, logic [14:0] thr,
                               logic [15:0] hold);
        drain();
        write_reg(REG_GRAVITY, g);
        write_reg(REG_LIMIT, lim);
        write_reg(REG_FTHR, {1'b0, thr});
        write_reg(REG_HOLDOFF, hold);
        cfg.valid <= 1'b0;
        cur_grav  = g;
        cur_limit = lim;
    endtask

    // readings mostly around the gravity offset, some at the limit edge
    function automatic logic [ACCEL_W-1:0] pick_z();
        int d;
        int v;
        case ($urandom_range(9))
            0, 1: return 16'($urandom());
            2: d = int'(cur_limit) - $urandom_range(1);
            3, 4: d = $urandom_range(200);
            default: d = $urandom_range((cur_limit < 64) ? 64 : int'(cur_limit));
        endcase
        if ($urandom_range(1))
            d = -d;
        v = int'(cur_grav) + d;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[ACCEL_W-1:0];
    endfunction

    task automatic run_random(int count);
        int  r;
        op_t op;
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
                drain();
            r  = $urandom_range(99);
            op = (r < 55) ? OP_SAMPLE : (r < 93) ? OP_TICK : (r < 97) ? OP_DONE : OP_UNUSED;
            send(op, (op == OP_SAMPLE) ? pick_z() : 16'($urandom()));
        end
    endtask

    initial
    begin
        item.valid   <= 1'b0;
        item.op      <= OP_SAMPLE;
        item.accel_z <= '0;
        cfg.valid    <= 1'b0;
        cfg.index    <= REG_GRAVITY;
        cfg.data     <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zero deviation, just below and at the limit, rails
        send(OP_SAMPLE, 16'sd15695);
        send(OP_SAMPLE, 16'sd25694);
        send(OP_SAMPLE, 16'sd5695);
        send(OP_SAMPLE, 16'sd5696);
        send(OP_SAMPLE, 16'sh7FFF);
        send(OP_SAMPLE, 16'sh8000);
        send(OP_UNUSED, 16'hFFFF);
        send(OP_TICK, 16'h0000);
        send(OP_DONE, 16'hFFFF);

        // large deviations saturate the entry, the widest meets the limit; zero holdoff
        load_config(16'h8000, 16'hFFFF, 15'd0, 16'd0);
        send(OP_SAMPLE, 16'sh7FFF);
        send(OP_SAMPLE, 16'sd0);
        send(OP_SAMPLE, 16'sh8000);
        send(OP_TICK, 16'h1234);
        send(OP_SAMPLE, -16'sd32767);
        send(OP_TICK, 16'h0);
        send(OP_DONE, 16'h0);
        send(OP_SAMPLE, -16'sd32700);
        send(OP_UNUSED, 16'h0);

        // zero limit: nothing contributes
        load_config(16'h7FFF, 16'h0000, 15'd25600, 16'hFFFF);
        send(OP_SAMPLE, 16'sh7FFF);
        send(OP_SAMPLE, 16'sh8000);
        send(OP_TICK, 16'h5555);

        // ms counter one above the holdoff detects; right after, a lower holdoff still blocks
        load_config(16'h0000, 16'hFFFF, 15'd0, 16'd40);
        idling = 1'b0;
        repeat (40)
            send(OP_TICK, 16'($urandom()));
        send(OP_SAMPLE, 16'sd1000);
        drain();
        write_reg(REG_HOLDOFF, 16'd39);
        cfg.valid <= 1'b0;
        send(OP_SAMPLE, -16'sd1000);
        idling = 1'b1;

        load_config(16'($urandom()), 16'($urandom()), 15'($urandom_range(3000)),
                    16'($urandom_range(40)));
        run_random(200);
        load_config(16'h7FFF, 16'hFFFF, 15'd25600, 16'hFFFF);
        run_random(150);
        load_config(16'h8000, 16'($urandom_range(65535, 16384)), 15'd0, 16'd0);
        run_random(150);
        idling = 1'b0;
        load_config(16'($urandom()), 16'($urandom()), 15'($urandom_range(2000)),
                    16'($urandom_range(20)));
        run_random(250);
        idling = 1'b1;
        load_config(16'($urandom()), 16'($urandom()), 15'($urandom_range(25600)),
                    16'($urandom_range(60)));
        run_random(250);
        load_config(16'($urandom()), 16'($urandom_range(2000, 1)),
                    15'($urandom_range(1500)), 16'($urandom_range(20)));
        run_random(200);

        drain();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: accel_fall_detector.f
rtl/afd_pkg.sv
rtl/afd_if.sv
rtl/afd_isqrt.sv
rtl/accel_fall_detector.sv
rtl/afd_checker.sv
sim/afd_fall_monitor.sv
sim/tb.sv
